// File: design/pffm_pkg.sv
// Package with types, constants and saturating helper functions of the pulsed filament flow monitor.
`default_nettype none
package pffm_pkg;
   typedef enum logic [1:0] {
      OP_PULSE = 2'd0,
      OP_CHECK = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_MM_PER_PULSE = 3'd0,
      REG_MIN_PCT      = 3'd1,
      REG_MAX_PCT      = 3'd2,
      REG_CHECK_LENGTH = 3'd3,
      REG_ENABLE_MODE  = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      FLOW_OK     = 2'd0,
      FLOW_LITTLE = 2'd1,
      FLOW_MUCH   = 2'd2
   } flow_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_DECIDE,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [31:0]        now_ms;
      logic               is_printing;
      logic               from_isr;
      logic [31:0]        isr_ms;
      logic signed [31:0] consumed;
      logic [31:0]        printing_since_ms;
   } req_type;

   typedef struct packed {
      logic               fetch_request;
      logic [1:0]         flow_status;
      logic               data_received;
      logic               calibration_valid;
      logic signed [31:0] min_ratio;
      logic signed [31:0] max_ratio;
      logic signed [31:0] total_commanded;
      logic [30:0]        total_measured;
   } rsp_type;

   localparam logic [31:0] PULSE_GAP_MS  = 32'd50;
   localparam logic [31:0] OVERDUE_MS    = 32'd220;
   localparam logic [6:0]  SAMPLE_CAP    = 7'd100;
   localparam logic [31:0] SYNC_DELAY_MS = 32'd10;
   localparam logic signed [31:0] CALIB_MIN_CMD = 32'sd1310720;
   localparam logic [31:0] COUNT_MAX = 32'h7FFF_FFFF;
   localparam int QUOT_BITS = 48;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sh0_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] add_count(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[31:0];
   endfunction
endpackage
`default_nettype wire

// File: design/pulsed_filament_flow_monitor.sv
// Top level of the pulsed filament flow monitor with a serial ratio divider.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    pffm_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready    pffm_pkg::rsp_type
//   csr      in         csr_write_enable       csr_index, csr_write_data
//
// A pulse, a clear or a check without a comparison passes through the fold and decide
// states to the output state, where it presents its result. A check word that runs a
// comparison goes on through the prep, divide and finish states, where the one-bit-per-cycle
// restoring divider forms the ratio (48 quotient bits). Ready returns the cycle after the result is taken.
// Reset is synchronous and restores register defaults and zero state.
// The block takes no word while one is in work or its result is held.
`default_nettype none
module pulsed_filament_flow_monitor (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pffm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pffm_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [2:0]        csr_index,
   input  wire logic [23:0]       csr_write_data
);
   import pffm_pkg::*;

   state_type state_ff, state_in;
   req_type   req_ff;

   logic [23:0] mm_per_pulse_ff;
   logic [15:0] min_pct_ff, max_pct_ff;
   logic [23:0] check_length_ff;
   logic [1:0]  enable_mode_ff;

   logic [31:0] pending_ff, pending_in;
   logic [6:0]  samples_ff, samples_in;
   logic [31:0] last_request_ff, last_request_in;
   logic signed [31:0] seg_cmd_ff, seg_cmd_in, sync_cmd_ff, sync_cmd_in;
   logic [31:0] seg_meas_ff, seg_meas_in, sync_meas_ff, sync_meas_in;
   logic signed [31:0] lat_cmd_ff, lat_cmd_in;
   logic        lat_print_ff, lat_print_in, have_lat_ff, have_lat_in;
   logic [31:0] lat_isr_ff, lat_isr_in, last_sync_ff, last_sync_in;
   logic        cmp_started_ff, cmp_started_in, cal_started_ff, cal_started_in;
   logic signed [31:0] ratio_low_ff, ratio_low_in, ratio_high_ff, ratio_high_in;
   logic signed [31:0] cal_cmd_ff, cal_cmd_in;
   logic [31:0] cal_meas_ff, cal_meas_in;
   logic        fetch_ff, fetch_in;
   logic [1:0]  status_ff, status_in;

   // Comparison operands and divider state.
   logic signed [31:0] cmp_cmd_ff, cmp_cmd_in;
   logic [31:0] cmp_meas_ff, cmp_meas_in;
   logic [55:0] meas_len_ff, meas_len_in;
   logic [63:0] rem_ff, rem_in;
   logic [47:0] quot_ff, quot_in;
   logic [63:0] dividend_ff, dividend_in;
   logic [5:0]  count_ff, count_in;
   logic        start_cmp;

   logic [31:0] fold_d;
   logic [31:0] fold_sync_meas;
   logic signed [33:0] lim_sum;
   logic [31:0] mag;
   logic [64:0] rem_shift;
   logic signed [31:0] ratio;
   logic signed [63:0] m100, lo_prod, hi_prod;
   logic [15:0] lo_pct, hi_pct;
   logic signed [33:0] cal_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         mm_per_pulse_ff <= 24'd65536;
         min_pct_ff      <= 16'd60;
         max_pct_ff      <= 16'd160;
         check_length_ff <= 24'd196608;
         enable_mode_ff  <= 2'd0;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_MM_PER_PULSE: mm_per_pulse_ff <= csr_write_data;
            REG_MIN_PCT:      min_pct_ff <= csr_write_data[15:0];
            REG_MAX_PCT:      max_pct_ff <= csr_write_data[15:0];
            REG_CHECK_LENGTH: check_length_ff <= csr_write_data;
            REG_ENABLE_MODE:  enable_mode_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_FOLD;
         ST_FOLD:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = start_cmp ? ST_PREP : ST_OUT;
         ST_PREP:   state_in = ST_DIVIDE;
         ST_DIVIDE: if (count_ff == 6'd0) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUT;
         ST_OUT:    if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      pending_in = pending_ff; samples_in = samples_ff; last_request_in = last_request_ff;
      seg_cmd_in = seg_cmd_ff; sync_cmd_in = sync_cmd_ff;
      seg_meas_in = seg_meas_ff; sync_meas_in = sync_meas_ff;
      lat_cmd_in = lat_cmd_ff; lat_print_in = lat_print_ff; have_lat_in = have_lat_ff;
      lat_isr_in = lat_isr_ff; last_sync_in = last_sync_ff;
      cmp_started_in = cmp_started_ff; cal_started_in = cal_started_ff;
      ratio_low_in = ratio_low_ff; ratio_high_in = ratio_high_ff;
      cal_cmd_in = cal_cmd_ff; cal_meas_in = cal_meas_ff;
      fetch_in = fetch_ff; status_in = status_ff;
      cmp_cmd_in = cmp_cmd_ff; cmp_meas_in = cmp_meas_ff; meas_len_in = meas_len_ff;
      rem_in = rem_ff; quot_in = quot_ff; dividend_in = dividend_ff;
      count_in = count_ff; start_cmp = 1'b0;
      fold_d = last_sync_ff - req_ff.printing_since_ms;
      fold_sync_meas = add_count(sync_meas_ff, pending_ff);
      lim_sum = 34'(seg_cmd_ff) + 34'(sync_cmd_ff);
      mag = cmp_cmd_ff[31] ? (~cmp_cmd_ff + 32'd1) : cmp_cmd_ff;
      rem_shift = {rem_ff, dividend_ff[63]};
      ratio = '0;
      m100 = '0; lo_prod = '0; hi_prod = '0;
      lo_pct = '0; hi_pct = '0; cal_sum = '0;
      case (state_ff)
         ST_IDLE: begin
            fetch_in = 1'b0;
            status_in = FLOW_OK;
            if (req_valid && opcode_type'(req_data.opcode) == OP_PULSE) begin
               if (pending_ff != 32'hFFFF_FFFF) pending_in = pending_ff + 32'd1;
               if (samples_ff < SAMPLE_CAP) samples_in = samples_ff + 7'd1;
               if (req_data.now_ms - last_request_ff >= PULSE_GAP_MS) begin
                  last_request_in = req_data.now_ms;
                  fetch_in = 1'b1;
               end
            end else if (req_valid && opcode_type'(req_data.opcode) == OP_CHECK) begin
               sync_cmd_in = sat32(34'(sync_cmd_ff) + 34'(req_data.consumed));
               if (req_data.from_isr) begin
                  lat_cmd_in = sync_cmd_in;
                  lat_print_in = req_data.is_printing;
                  lat_isr_in = req_data.isr_ms;
                  have_lat_in = 1'b1;
               end
            end
         end
         ST_FOLD: begin
            if (opcode_type'(req_ff.opcode) == OP_CHECK
                || opcode_type'(req_ff.opcode) == OP_CLEAR) begin
               sync_meas_in = fold_sync_meas;
               pending_in = '0;
               if (have_lat_ff) begin
                  if (lat_print_ff && !fold_d[31] && fold_d > SYNC_DELAY_MS) begin
                     seg_cmd_in = sat32(34'(seg_cmd_ff) + 34'(lat_cmd_ff));
                     seg_meas_in = add_count(seg_meas_ff, fold_sync_meas);
                  end
                  last_sync_in = lat_isr_ff;
                  sync_cmd_in = sat32(34'(sync_cmd_ff) - 34'(lat_cmd_ff));
                  sync_meas_in = '0;
                  have_lat_in = 1'b0;
               end
               if (opcode_type'(req_ff.opcode) == OP_CLEAR) begin
                  seg_cmd_in = '0; sync_cmd_in = '0;
                  seg_meas_in = '0; sync_meas_in = '0;
                  cmp_started_in = 1'b0; have_lat_in = 1'b0; lat_print_in = 1'b0;
               end
            end
         end
         ST_DECIDE: begin
            if (opcode_type'(req_ff.opcode) == OP_CHECK) begin
               if (seg_cmd_ff >= $signed({8'd0, check_length_ff})) begin
                  start_cmp = 1'b1;
                  cmp_cmd_in = seg_cmd_ff;
                  cmp_meas_in = seg_meas_ff;
                  seg_cmd_in = '0; seg_meas_in = '0;
               end else if (lim_sum >= $signed({9'd0, check_length_ff, 1'b0})
                            && req_ff.now_ms - last_request_ff > OVERDUE_MS) begin
                  start_cmp = 1'b1;
                  cmp_cmd_in = sat32(lim_sum);
                  cmp_meas_in = add_count(seg_meas_ff, sync_meas_ff);
                  seg_cmd_in = '0; sync_cmd_in = '0;
                  seg_meas_in = '0; sync_meas_in = '0;
               end
            end
         end
         ST_PREP: begin
            meas_len_in = cmp_meas_ff * mm_per_pulse_ff;
            rem_in = '0;
            quot_in = '0;
            count_in = 6'(QUOT_BITS - 1);
         end
         ST_DIVIDE: begin
            // The dividend is the length shifted up by 16; its bits above the
            // low 48 preload the remainder.
            if (count_ff == 6'(QUOT_BITS - 1)) begin
               rem_shift = {49'd0, meas_len_ff[46:31]};
            end
            if (count_ff == 6'(QUOT_BITS - 1)) begin
               dividend_in = {meas_len_ff[30:0], 33'd0};
            end else begin
               dividend_in = {dividend_ff[62:0], 1'b0};
            end
            if (rem_shift >= {33'd0, mag}) begin
               rem_in = 64'(rem_shift - {33'd0, mag});
               quot_in = {quot_ff[46:0], 1'b1};
            end else begin
               rem_in = rem_shift[63:0];
               quot_in = {quot_ff[46:0], 1'b0};
            end
            if (count_ff != 6'd0) count_in = count_ff - 6'd1;
         end
         ST_FINISH: begin
            if (cmp_cmd_ff == 32'sd0) begin
               ratio = (meas_len_ff != '0) ? 32'sh7FFF_FFFF : 32'sd0;
            end else if (meas_len_ff[55:47] != '0
                         || {17'd0, meas_len_ff[46:32]} >= mag) begin
               ratio = cmp_cmd_ff[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else if (cmp_cmd_ff[31]) begin
               ratio = (quot_ff[47:31] != '0) ? 32'sh8000_0000 : -$signed(quot_ff[31:0]);
            end else begin
               ratio = (quot_ff[47:31] != '0) ? 32'sh7FFF_FFFF : $signed(quot_ff[31:0]);
            end
            if (!cmp_started_ff) begin
               cmp_started_in = 1'b1;
               cal_started_in = 1'b0;
            end else if (enable_mode_ff != 2'd0) begin
               lo_pct = cmp_cmd_ff[31] ? max_pct_ff : min_pct_ff;
               hi_pct = cmp_cmd_ff[31] ? min_pct_ff : max_pct_ff;
               m100 = $signed({8'd0, meas_len_ff}) * 64'sd100;
               lo_prod = 64'(cmp_cmd_ff) * $signed({48'd0, lo_pct});
               hi_prod = 64'(cmp_cmd_ff) * $signed({48'd0, hi_pct});
               if (m100 < lo_prod) status_in = FLOW_LITTLE;
               else if (m100 > hi_prod) status_in = FLOW_MUCH;
            end
            if (cmp_started_ff && cal_started_ff) begin
               if (ratio < ratio_low_ff) ratio_low_in = ratio;
               if (ratio > ratio_high_ff) ratio_high_in = ratio;
               cal_sum = 34'(cal_cmd_ff) + 34'(cmp_cmd_ff);
               cal_cmd_in = sat32(cal_sum);
               cal_meas_in = add_count(cal_meas_ff, cmp_meas_ff);
            end else begin
               ratio_low_in = ratio; ratio_high_in = ratio;
               cal_cmd_in = cmp_cmd_ff;
               cal_meas_in = (cmp_meas_ff > COUNT_MAX) ? COUNT_MAX : cmp_meas_ff;
               cal_started_in = 1'b1;
            end
            if (enable_mode_ff == 2'd0) status_in = FLOW_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pending_ff <= '0; samples_ff <= '0; last_request_ff <= '0;
         seg_cmd_ff <= '0; sync_cmd_ff <= '0; seg_meas_ff <= '0; sync_meas_ff <= '0;
         lat_cmd_ff <= '0; lat_print_ff <= 1'b0; have_lat_ff <= 1'b0;
         lat_isr_ff <= '0; last_sync_ff <= '0;
         cmp_started_ff <= 1'b0; cal_started_ff <= 1'b0;
         ratio_low_ff <= '0; ratio_high_ff <= '0; cal_cmd_ff <= '0; cal_meas_ff <= '0;
         fetch_ff <= 1'b0; status_ff <= FLOW_OK; count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pending_ff <= pending_in; samples_ff <= samples_in;
         last_request_ff <= last_request_in;
         seg_cmd_ff <= seg_cmd_in; sync_cmd_ff <= sync_cmd_in;
         seg_meas_ff <= seg_meas_in; sync_meas_ff <= sync_meas_in;
         lat_cmd_ff <= lat_cmd_in; lat_print_ff <= lat_print_in; have_lat_ff <= have_lat_in;
         lat_isr_ff <= lat_isr_in; last_sync_ff <= last_sync_in;
         cmp_started_ff <= cmp_started_in; cal_started_ff <= cal_started_in;
         ratio_low_ff <= ratio_low_in; ratio_high_ff <= ratio_high_in;
         cal_cmd_ff <= cal_cmd_in; cal_meas_ff <= cal_meas_in;
         fetch_ff <= fetch_in; status_ff <= status_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) req_ff <= req_data;
      cmp_cmd_ff <= cmp_cmd_in; cmp_meas_ff <= cmp_meas_in;
      meas_len_ff <= meas_len_in; rem_ff <= rem_in; quot_ff <= quot_in;
      dividend_ff <= dividend_in;
   end

   always_comb begin
      rsp_data.fetch_request     = fetch_ff;
      rsp_data.flow_status       = status_ff;
      rsp_data.data_received     = (samples_ff >= 7'd2);
      rsp_data.calibration_valid = cal_started_ff && cal_meas_ff > 32'd1
                                   && cal_cmd_ff > CALIB_MIN_CMD;
      rsp_data.min_ratio         = ratio_low_ff;
      rsp_data.max_ratio         = ratio_high_ff;
      rsp_data.total_commanded   = cal_cmd_ff;
      rsp_data.total_measured    = cal_meas_ff[30:0];
   end
endmodule
`default_nettype wire
